### src/cfq_pkg.sv
// Shared types and constants for the circular FIFO queue unit.
// No dependencies; used by cfq_ptr, the top level and the checker.
package cfq_pkg;

    // Payload widths
    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int CAP_W  = 5;

    // Default depth of the word store
    localparam int MAX_CAPACITY_DEF = 16;

    // Capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Head and tail words reported for an empty queue
    localparam logic [DATA_W-1:0] EMPTY_WORD = {DATA_W{1'b1}};

    // Operation codes
    localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
    localparam logic [OP_W-1:0] OP_ENQ   = 2'd1;
    localparam logic [OP_W-1:0] OP_DEQ   = 2'd2;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    // Status from the pointer unit to the top level
    typedef struct packed {
        logic wr_en;   // store write for an accepted enqueue
        logic ok;      // success flag of the last transaction
        logic empty;   // no words held
        logic full;    // capacity words held
    } t_q_flags;

endpackage

### src/cfq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module cfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/cfq_ptr.sv
// Pointer unit: capacity register, head/tail indexes and fill count.
// Depends on cfq_pkg.
module cfq_ptr #(
    parameter int MAX_CAPACITY = cfq_pkg::MAX_CAPACITY_DEF,
    parameter int IDX_W = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [cfq_pkg::CAP_W-1:0]  i_cfg_wdata,
    input  logic                       i_step,
    input  logic [cfq_pkg::OP_W-1:0]   i_op,
    output logic [IDX_W-1:0]           o_wr_addr,
    output logic [IDX_W-1:0]           o_head_addr,
    output logic [IDX_W-1:0]           o_last_addr,
    output cfq_pkg::t_q_flags          o_flags
);

    localparam int CNT_W = $clog2(MAX_CAPACITY + 1);
    localparam int CX_W  = (CNT_W > cfq_pkg::CAP_W) ? CNT_W : cfq_pkg::CAP_W;
    localparam logic [CX_W-1:0] MAX_CX = CX_W'(MAX_CAPACITY);

    logic [cfq_pkg::CAP_W-1:0] r_cap;
    logic [IDX_W-1:0]          r_head, n_head;
    logic [IDX_W-1:0]          r_tail, n_tail;
    logic [CNT_W-1:0]          r_fill, n_fill;
    logic                      r_ok, n_ok;

    logic [CX_W-1:0]  cap_x;
    logic [CX_W-1:0]  cap_sat;
    logic [CNT_W-1:0] cap_eff;
    logic [CNT_W-1:0] head_inc;
    logic [CNT_W-1:0] tail_inc;
    logic [CNT_W-1:0] tail_ext;
    logic             can_enq;
    logic             can_deq;

    // Effective capacity: zero acts as one, large values saturate
    always_comb begin
        cap_x = CX_W'(r_cap);
        if (cap_x == '0) begin
            cap_sat = CX_W'(1);
        end else if (cap_x > MAX_CX) begin
            cap_sat = MAX_CX;
        end else begin
            cap_sat = cap_x;
        end
    end
    assign cap_eff = cap_sat[CNT_W-1:0];

    // Wrapping increments
    assign head_inc = CNT_W'(r_head) + CNT_W'(1);
    assign tail_inc = CNT_W'(r_tail) + CNT_W'(1);
    assign tail_ext = CNT_W'(r_tail);

    assign can_enq = (r_fill < cap_eff);
    assign can_deq = (r_fill != '0);

    // Next pointer state for one transaction
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        n_ok   = r_ok;
        if (i_step) begin
            n_ok = 1'b0;
            case (i_op)
                cfq_pkg::OP_QUERY: begin
                    n_ok = 1'b1;
                end
                cfq_pkg::OP_ENQ: begin
                    if (can_enq) begin
                        n_tail = (tail_inc >= cap_eff) ? '0 : IDX_W'(tail_inc);
                        n_fill = r_fill + CNT_W'(1);
                        n_ok   = 1'b1;
                    end
                end
                cfq_pkg::OP_DEQ: begin
                    if (can_deq) begin
                        n_head = (head_inc >= cap_eff) ? '0 : IDX_W'(head_inc);
                        n_fill = r_fill - CNT_W'(1);
                        n_ok   = 1'b1;
                    end
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase
        end
    end

    // Registers; a capacity write empties the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= cfq_pkg::CAP_RESET;
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
            r_ok   <= 1'b0;
        end else if (i_cfg_we) begin
            r_cap  <= i_cfg_wdata;
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
            r_ok   <= n_ok;
        end
    end

    // Store addresses
    assign o_wr_addr   = r_tail;
    assign o_head_addr = r_head;
    assign o_last_addr = (r_tail == '0) ? IDX_W'(cap_eff - CNT_W'(1))
                                        : IDX_W'(tail_ext - CNT_W'(1));

    // Status
    assign o_flags.wr_en = i_step && (i_op == cfq_pkg::OP_ENQ) && can_enq;
    assign o_flags.ok    = r_ok;
    assign o_flags.empty = (r_fill == '0);
    assign o_flags.full  = (r_fill >= cap_eff);

endmodule

### src/circular_fifo_queue_unit.sv
// Circular FIFO queue unit: bounded queue of signed 32-bit words.
// Result: the store is read, then loaded into the output register; the load waits while a result is stalled.
// A new transaction is accepted only once the last one has passed write, store read and load of result.
// The store read port sets this pace: head and tail are read back after the write.
// Reset (synchronous, active low) empties the queue and sets capacity to 16.
// Depends on cfq_pkg, cfq_ptr and cfq_ram.
module circular_fifo_queue_unit #(
    parameter int MAX_CAPACITY = cfq_pkg::MAX_CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cfq_pkg::CAP_W-1:0]         i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [cfq_pkg::OP_W-1:0]          i_operation,
    input  logic signed [cfq_pkg::DATA_W-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_ok,
    output logic signed [cfq_pkg::DATA_W-1:0] o_head_value,
    output logic signed [cfq_pkg::DATA_W-1:0] o_tail_value,
    output logic                              o_is_empty,
    output logic                              o_is_full
);

    localparam int IDX_W = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;

    cfq_pkg::t_state   r_state, n_state;
    cfq_pkg::t_q_flags flags;

    logic                      step;
    logic                      load;
    logic [IDX_W-1:0]          wr_addr;
    logic [IDX_W-1:0]          head_addr;
    logic [IDX_W-1:0]          last_addr;
    logic [cfq_pkg::DATA_W-1:0] head_rd;
    logic [cfq_pkg::DATA_W-1:0] tail_rd;

    logic                       r_out_valid;
    logic                       r_ok;
    logic [cfq_pkg::DATA_W-1:0] r_head_val;
    logic [cfq_pkg::DATA_W-1:0] r_tail_val;
    logic                       r_empty;
    logic                       r_full;

    assign o_ready = (r_state == cfq_pkg::S_IDLE);
    assign step    = i_valid && o_ready;
    assign load    = (r_state == cfq_pkg::S_LOAD) && (!r_out_valid || i_ready);

    // Pointers, fill count and capacity
    cfq_ptr #(
        .MAX_CAPACITY (MAX_CAPACITY),
        .IDX_W        (IDX_W)
    ) u_ptr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (step),
        .i_op        (i_operation),
        .o_wr_addr   (wr_addr),
        .o_head_addr (head_addr),
        .o_last_addr (last_addr),
        .o_flags     (flags)
    );

    // Two copies of the word store: one read port for head, one for tail
    cfq_ram #(
        .WIDTH (cfq_pkg::DATA_W),
        .DEPTH (MAX_CAPACITY),
        .AW    (IDX_W)
    ) u_ram_head (
        .i_clk   (i_clk),
        .i_we    (flags.wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_value),
        .i_raddr (head_addr),
        .o_rdata (head_rd)
    );

    cfq_ram #(
        .WIDTH (cfq_pkg::DATA_W),
        .DEPTH (MAX_CAPACITY),
        .AW    (IDX_W)
    ) u_ram_tail (
        .i_clk   (i_clk),
        .i_we    (flags.wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_value),
        .i_raddr (last_addr),
        .o_rdata (tail_rd)
    );

    // Sequencer: accept, read back after the write, load result
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cfq_pkg::S_IDLE: begin
                if (step) begin
                    n_state = cfq_pkg::S_READ;
                end
            end
            cfq_pkg::S_READ: begin
                n_state = cfq_pkg::S_LOAD;
            end
            cfq_pkg::S_LOAD: begin
                if (load) begin
                    n_state = cfq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cfq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ok       <= flags.ok;
            r_empty    <= flags.empty;
            r_full     <= flags.full;
            r_head_val <= flags.empty ? cfq_pkg::EMPTY_WORD : head_rd;
            r_tail_val <= flags.empty ? cfq_pkg::EMPTY_WORD : tail_rd;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_ok         = r_ok;
    assign o_head_value = r_head_val;
    assign o_tail_value = r_tail_val;
    assign o_is_empty   = r_empty;
    assign o_is_full    = r_full;

endmodule

### src/cfq_checker.sv
// Port-level checker for circular_fifo_queue_unit, bound to the top level.
// Depends on cfq_pkg.
module cfq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic                              o_ok,
    input logic signed [cfq_pkg::DATA_W-1:0] o_head_value,
    input logic signed [cfq_pkg::DATA_W-1:0] o_tail_value,
    input logic                              o_is_empty,
    input logic                              o_is_full
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_ok) && $stable(o_head_value)
            && $stable(o_tail_value) && $stable(o_is_empty) && $stable(o_is_full)))
        else $error("result changed while stalled");

    // Empty queue reports all-ones words
    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |->
            (o_head_value == cfq_pkg::EMPTY_WORD && o_tail_value == cfq_pkg::EMPTY_WORD))
        else $error("empty queue must report all-ones words");

    // Capacity is at least one, so empty and full exclude each other
    a_empty_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_empty && o_is_full))
        else $error("empty and full together");

    // One transaction at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("accepted a transaction while one is in flight");

endmodule

bind circular_fifo_queue_unit cfq_checker u_cfq_checker (.*);
